// ===== rtl/jetp_pkg.sv =====
// Package with shared constants and types of the Julia escape-time pixel unit.
`timescale 1ns / 1ps
`default_nettype none
package jetp_pkg;

  localparam int unsigned MaxIterDef   = 250;
  localparam int unsigned ImgHeightDef = 800;
  localparam int unsigned ImgWidthDef  = 800;

  localparam int unsigned FracBits = 28;
  localparam int unsigned ZW       = 32;
  localparam int unsigned CW       = 30;
  localparam int unsigned OffW     = 13;
  localparam int unsigned CoordW   = 10;
  localparam int unsigned DivisW   = 14;
  localparam int unsigned MagW     = 14;
  localparam int unsigned MapDivW  = MagW + FracBits;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 30;

  localparam logic [CfgIdxW-1:0] RegCReal  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCImag  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegOffX   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegOffY   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSat    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegVal    = 3'd5;

  localparam logic [CW-1:0] CRealRst = 30'd76504105;
  localparam logic [CW-1:0] CImagRst = 30'd2684355;
  localparam logic [7:0]    SatRst   = 8'd150;
  localparam logic [7:0]    ValRst   = 8'd150;

  typedef struct packed {
    logic signed [ZW-1:0] zr;
    logic signed [ZW-1:0] zi;
  } start_t;

  typedef struct packed {
    logic signed [CW-1:0] c_real;
    logic signed [CW-1:0] c_imag;
    logic [7:0]           sat;
    logic [7:0]           val;
  } back_cfg_t;

endpackage
`default_nettype wire

// ===== rtl/jetp_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module jetp_div #(
  parameter int unsigned DW = 42,
  parameter int unsigned SW = 14
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [SW-1:0] divisor_i,
  output logic               done_o,
  output logic [DW-1:0]      quot_o
);
  localparam int unsigned CntW = $clog2(DW + 1);

  logic [DW-1:0]   acc_q, acc_d;
  logic [SW:0]     rem_q, rem_d;
  logic [SW-1:0]   dvs_q, dvs_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            run_q, run_d;
  logic            done_q, done_d;
  logic [SW:0]     trial;
  logic            fits;

  always_comb begin
    trial  = {rem_q[SW-1:0], acc_q[DW-1]};
    fits   = trial >= {1'b0, dvs_q};
    acc_d  = acc_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
      cnt_d = CntW'(DW);
      run_d = 1'b1;
    end else if (run_q) begin
      rem_d = fits ? (trial - {1'b0, dvs_q}) : trial;
      acc_d = {acc_q[DW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = acc_q;
endmodule
`default_nettype wire

// ===== rtl/jetp_front.sv =====
// Front end: accepts pixels and maps them to complex start points.
`timescale 1ns / 1ps
`default_nettype none
module jetp_front import jetp_pkg::*; #(
  parameter int unsigned IMG_HEIGHT = ImgHeightDef,
  parameter int unsigned IMG_WIDTH  = ImgWidthDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [CoordW-1:0]      row_i,
  input  wire logic [CoordW-1:0]      col_i,
  input  wire logic signed [OffW-1:0] offset_x_i,
  input  wire logic signed [OffW-1:0] offset_y_i,
  output logic                        push_o,
  output start_t                      push_data_o,
  input  wire logic                   full_i
);
  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } fstate_e;

  fstate_e             state_q, state_d;
  logic [CoordW-1:0]   row_q, row_d, col_q, col_d;
  logic                sel_q, sel_d, start_q, start_d;
  logic signed [ZW-1:0] zr_q, zr_d, zi_q, zi_d;

  logic signed [14:0]  img, off_s, lim, offc, dval;
  logic signed [15:0]  num;
  logic                neg;
  logic [15:0]         mag16;
  logic [DivisW-1:0]   divisor;
  logic [MapDivW-1:0]  dividend, quot;
  logic                div_done;
  logic [ZW-1:0]       sat_val;

  always_comb begin
    img      = sel_q ? 15'(IMG_HEIGHT) : 15'(IMG_WIDTH);
    off_s    = sel_q ? 15'(offset_x_i) : 15'(offset_y_i);
    lim      = img - 15'sd2;
    offc     = (off_s > lim) ? lim : off_s;
    dval     = img - offc;
    num      = 16'(2 * $signed({1'b0, sel_q ? row_q : col_q})) - 16'(dval);
    neg      = num[15];
    mag16    = neg ? 16'(-num) : 16'(num);
    divisor  = dval[DivisW-1:0];
    dividend = {mag16[MagW-1:0], {FracBits{1'b0}}};
    if (neg) begin
      sat_val = (quot > MapDivW'(64'h8000_0000)) ? 32'h8000_0000 : 32'(-quot[ZW-1:0]);
    end else begin
      sat_val = (quot >= MapDivW'(64'h8000_0000)) ? 32'h7FFF_FFFF : quot[ZW-1:0];
    end
  end

  jetp_div #(.DW(MapDivW), .SW(DivisW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_q),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    col_d   = col_q;
    sel_d   = sel_q;
    start_d = 1'b0;
    zr_d    = zr_q;
    zi_d    = zi_q;
    push_o  = 1'b0;
    unique case (state_q)
      F_IDLE: begin
        if (in_valid_i) begin
          row_d   = row_i;
          col_d   = col_i;
          sel_d   = 1'b0;
          start_d = 1'b1;
          state_d = F_DIV;
        end
      end
      F_DIV: begin
        if (div_done) begin
          if (!sel_q) begin
            zr_d    = sat_val;
            sel_d   = 1'b1;
            start_d = 1'b1;
          end else begin
            zi_d    = sat_val;
            state_d = F_PUSH;
          end
        end
      end
      F_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      start_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= start_d;
      sel_q   <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q <= row_d;
    col_q <= col_d;
    zr_q  <= zr_d;
    zi_q  <= zi_d;
  end

  assign in_ready_o     = (state_q == F_IDLE);
  assign push_data_o.zr = zr_q;
  assign push_data_o.zi = zi_q;
endmodule
`default_nettype wire

// ===== rtl/jetp_fifo.sv =====
// Two-entry queue of start points between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module jetp_fifo import jetp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  start_t    push_data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output start_t    pop_data_o,
  output logic      empty_o
);
  start_t     mem [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wp_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= ~wp_q;
      end
      if (pop_i) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  assign pop_data_o = mem[rp_q];
  assign full_o     = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
endmodule
`default_nettype wire

// ===== rtl/jetp_back.sv =====
// Back end: escape-time iteration, hue tracking and byte-wise HSV colouring.
`timescale 1ns / 1ps
`default_nettype none
module jetp_back import jetp_pkg::*; #(
  parameter int unsigned MAX_ITER = MaxIterDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  empty_i,
  input  start_t     pop_data_i,
  output logic       pop_o,
  input  back_cfg_t  cfg_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output logic [7:0] iter_o,
  output logic       inside_o,
  output logic [7:0] chan0_o,
  output logic [7:0] chan1_o,
  output logic [7:0] chan2_o
);
  localparam int unsigned IW = $clog2(MAX_ITER + 1);
  localparam int unsigned NW = (IW > 8) ? IW : 8;
  localparam int unsigned RW = IW + 1;

  localparam logic [RW-1:0] MaxIterR = RW'(MAX_ITER);
  localparam logic [RW-1:0] HueRem   = RW'(255 % MAX_ITER);
  localparam logic [7:0]    HueStep  = 8'(255 / MAX_ITER);

  typedef enum logic [5:0] {
    B_IDLE = 6'b000001,
    B_MUL  = 6'b000010,
    B_CHK  = 6'b000100,
    B_COL1 = 6'b001000,
    B_COL2 = 6'b010000,
    B_DONE = 6'b100000
  } bstate_e;

  bstate_e state_q, state_d;
  logic signed [ZW-1:0]   zr_q, zr_d, zi_q, zi_d;
  logic signed [2*ZW-1:0] rr_q, ii_q, ri_q;
  logic [NW-1:0]          n_q, n_d;
  logic [RW-1:0]          hr_q, hr_d;
  logic [7:0]             hq_q, hq_d;
  logic                   ins_q, ins_d;
  logic [7:0]             h_q, h_d;
  logic [1:0]             sect_q, sect_d;
  logic [15:0]            sf_q, sf_d, sg_q, sg_d;
  logic [7:0]             c0_q, c0_d, c1_q, c1_d, c2_q, c2_d;
  logic                   ov_q, ov_d;
  logic [7:0]             oit_q, oc0_q, oc1_q, oc2_q;
  logic                   oins_q;

  logic [2*ZW-1:0]        nrm;
  logic signed [2*ZW-1:0] dre, dim;
  logic [RW-1:0]          hsum;
  logic [6:0]             hm;
  logic [7:0]             f;
  logic signed [9:0]      pa, qa, ta;
  logic signed [18:0]     pp, qp, tp;
  logic [7:0]             pv, qv, tv, v;
  logic                   load;

  // The hue n*255/MAX_ITER is kept as quotient and remainder, stepped with n.
  always_comb begin
    nrm  = $unsigned(rr_q) + $unsigned(ii_q);
    dre  = (rr_q - ii_q) >>> FracBits;
    dim  = (ri_q <<< 1) >>> FracBits;
    hsum = hr_q + HueRem;
    hm   = (h_q >= 8'd200) ? 7'(h_q - 8'd200) :
           (h_q >= 8'd100) ? 7'(h_q - 8'd100) : h_q[6:0];
    f    = 8'(11'(hm) * 11'd9);
    v    = cfg_i.val;
    pa   = 10'sd22 - $signed({2'b0, cfg_i.sat});
    qa   = 10'sd185 - $signed({2'b0, sf_q[15:8]});
    ta   = 10'sd255 - $signed({2'b0, sg_q[15:8]});
    pp   = $signed({1'b0, v}) * pa;
    qp   = $signed({1'b0, v}) * qa;
    tp   = $signed({1'b0, v}) * ta;
    pv   = pp[15:8];
    qv   = qp[15:8];
    tv   = tp[15:8];
  end

  always_comb begin
    state_d = state_q;
    zr_d    = zr_q;
    zi_d    = zi_q;
    n_d     = n_q;
    hr_d    = hr_q;
    hq_d    = hq_q;
    ins_d   = ins_q;
    h_d     = h_q;
    sect_d  = sect_q;
    sf_d    = sf_q;
    sg_d    = sg_q;
    c0_d    = c0_q;
    c1_d    = c1_q;
    c2_d    = c2_q;
    pop_o   = 1'b0;
    load    = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          zr_d    = pop_data_i.zr;
          zi_d    = pop_data_i.zi;
          n_d     = '0;
          hr_d    = '0;
          hq_d    = '0;
          state_d = B_MUL;
        end
      end
      B_MUL: state_d = B_CHK;
      B_CHK: begin
        if (nrm >= 64'h0400_0000_0000_0000) begin
          ins_d   = 1'b0;
          h_d     = hq_q;
          state_d = B_COL1;
        end else if (n_q == NW'(MAX_ITER)) begin
          ins_d   = 1'b1;
          c0_d    = '0;
          c1_d    = '0;
          c2_d    = '0;
          state_d = B_DONE;
        end else begin
          zr_d    = dre[ZW-1:0] + ZW'(cfg_i.c_real);
          zi_d    = dim[ZW-1:0] + ZW'(cfg_i.c_imag);
          n_d     = n_q + 1'b1;
          if (hsum >= MaxIterR) begin
            hr_d = hsum - MaxIterR;
            hq_d = hq_q + HueStep + 8'd1;
          end else begin
            hr_d = hsum;
            hq_d = hq_q + HueStep;
          end
          state_d = B_MUL;
        end
      end
      B_COL1: begin
        sect_d  = (h_q >= 8'd200) ? 2'd2 : (h_q >= 8'd100) ? 2'd1 : 2'd0;
        sf_d    = cfg_i.sat * f;
        sg_d    = cfg_i.sat * (8'd255 - f);
        state_d = B_COL2;
      end
      B_COL2: begin
        case (sect_q)
          2'd0:    begin c0_d = v;  c1_d = tv; c2_d = pv; end
          2'd1:    begin c0_d = qv; c1_d = v;  c2_d = pv; end
          2'd2:    begin c0_d = pv; c1_d = v;  c2_d = tv; end
          default: begin c0_d = v;  c1_d = pv; c2_d = qv; end
        endcase
        if (cfg_i.sat == 8'd0) begin
          c0_d = '0;
          c1_d = '0;
          c2_d = '0;
        end
        state_d = B_DONE;
      end
      B_DONE: begin
        if (!ov_q || out_ready_i) begin
          load    = 1'b1;
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
    ov_d = load ? 1'b1 : (out_ready_i ? 1'b0 : ov_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zr_q   <= zr_d;
    zi_q   <= zi_d;
    n_q    <= n_d;
    hr_q   <= hr_d;
    hq_q   <= hq_d;
    ins_q  <= ins_d;
    h_q    <= h_d;
    sect_q <= sect_d;
    sf_q   <= sf_d;
    sg_q   <= sg_d;
    c0_q   <= c0_d;
    c1_q   <= c1_d;
    c2_q   <= c2_d;
    rr_q   <= zr_q * zr_q;
    ii_q   <= zi_q * zi_q;
    ri_q   <= zr_q * zi_q;
    if (load) begin
      oit_q  <= n_q[7:0];
      oins_q <= ins_q;
      oc0_q  <= c0_q;
      oc1_q  <= c1_q;
      oc2_q  <= c2_q;
    end
  end

  assign out_valid_o = ov_q;
  assign iter_o      = oit_q;
  assign inside_o    = oins_q;
  assign chan0_o     = oc0_q;
  assign chan1_o     = oc1_q;
  assign chan2_o     = oc2_q;
endmodule
`default_nettype wire

// ===== rtl/julia_escape_time_pixel_unit.sv =====
// Top level of the Julia escape-time pixel unit with its register file.
// The front end runs the two start-point divisions; the back end takes the point
// from the queue, iterates with the products of z registered in B_MUL and checked in
// B_CHK for up to MAX_ITER iterations, then colours in B_COL1 and B_COL2 and outputs.
// Throughput: one pixel per back-end run; the front end maps the next pixel meanwhile.
// Reset: registers take their default values, queue and output register are empty.
`timescale 1ns / 1ps
`default_nettype none
module julia_escape_time_pixel_unit import jetp_pkg::*; #(
  parameter int unsigned MAX_ITER   = MaxIterDef,
  parameter int unsigned IMG_HEIGHT = ImgHeightDef,
  parameter int unsigned IMG_WIDTH  = ImgWidthDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [23:0]         s_axis_tdata,  // row_coord, col_coord, pad
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [31:0]              m_axis_tdata,  // iter_count, chan0, chan1, chan2
  output logic                     m_axis_tuser,  // inside_set
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);
  logic signed [CW-1:0]   c_real_q, c_imag_q;
  logic signed [OffW-1:0] offx_q, offy_q;
  logic [7:0]             sat_q, val_q;
  back_cfg_t              bcfg;
  start_t                 push_data, pop_data;
  logic                   push, pop, full, empty;
  logic [7:0]             iter, ch0, ch1, ch2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_real_q <= CRealRst;
      c_imag_q <= CImagRst;
      offx_q   <= '0;
      offy_q   <= '0;
      sat_q    <= SatRst;
      val_q    <= ValRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegCReal: c_real_q <= cfg_data_i[CW-1:0];
        RegCImag: c_imag_q <= cfg_data_i[CW-1:0];
        RegOffX:  offx_q   <= cfg_data_i[OffW-1:0];
        RegOffY:  offy_q   <= cfg_data_i[OffW-1:0];
        RegSat:   sat_q    <= cfg_data_i[7:0];
        RegVal:   val_q    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign bcfg.c_real = c_real_q;
  assign bcfg.c_imag = c_imag_q;
  assign bcfg.sat    = sat_q;
  assign bcfg.val    = val_q;

  jetp_front #(.IMG_HEIGHT(IMG_HEIGHT), .IMG_WIDTH(IMG_WIDTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .row_i       (s_axis_tdata[9:0]),
    .col_i       (s_axis_tdata[19:10]),
    .offset_x_i  (offx_q),
    .offset_y_i  (offy_q),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  jetp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  jetp_back #(.MAX_ITER(MAX_ITER)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .cfg_i       (bcfg),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .iter_o      (iter),
    .inside_o    (m_axis_tuser),
    .chan0_o     (ch0),
    .chan1_o     (ch1),
    .chan2_o     (ch2)
  );

  assign m_axis_tdata = {ch2, ch1, ch0, iter};

  a_inside_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[31:8] == 24'd0)
    else $error("Inside pixel has a nonzero colour.");

  a_inside_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[7:0] == 8'(MAX_ITER))
    else $error("Inside pixel without the full iteration count.");

  a_no_sat_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && sat_q == 8'd0 |-> m_axis_tdata[31:8] == 24'd0)
    else $error("Zero saturation gave a nonzero colour.");
endmodule
`default_nettype wire
